FILE: rtl/first_fit_heap_allocator_assert.svh
// assertion macros for the heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FFHA_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define FFHA_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define FFHA_ASSERT_IMP(name, clk, rstn, ante, cons)
`define FFHA_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int HEAP_BYTES_DEF = 65536;
    localparam int UNIT_BYTES_DEF = 8;
    localparam int HDR_BYTES      = 8;
    localparam int DIV_W          = 17;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE, S_DIV, S_SETUP,
        S_A_RD, S_A_CHK, S_A_SPLIT, S_A_NRD, S_A_NWR,
        S_R_RD, S_R_CHK, S_R_NRD, S_R_NWR, S_R_PRD, S_R_BCLR, S_R_PWR,
        S_R_XRD, S_R_XCHK, S_R_XWB, S_R_FRD, S_R_FWR,
        S_DONE_A, S_DONE_R, S_FAIL
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_INIT0, OP_INIT1, OP_LOAD, OP_SETUP,
        OP_B_RD, OP_A_CHK, OP_A_SPLIT, OP_NXT_RD, OP_NXT_WR_A, OP_NXT_WR_R,
        OP_R_CHK, OP_P_RD, OP_B_CLR, OP_P_WR, OP_X_CHK, OP_X_WB,
        OP_OUT_A, OP_OUT_R, OP_OUT_FAIL
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic is_release;
        logic rel_bad_addr;
        logic at_end;
        logic tag_zero;
        logic fit;
        logic exact;
        logic rel_bad_tag;
        logic prev_merge;
        logic next_free;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/first_fit_heap_allocator.sv
// one word at a time; the divider turns the size or offset into units, then the tag walk runs
// allocate: the walk passes blocks up to the first fit, with an extra tag write when the block is split
// no fit: the walk runs up to the end sentinel; release merges free neighbours, or fails on a bad offset or tag
// one tag memory port sets the pace; the next word is taken once the result is in the output register
// reset: synchronous active low, then the free block and end sentinel tags are written in turn
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF,
    parameter int UNIT_BYTES = ffha_pkg::UNIT_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [15:0] s_request_bytes,
    input  logic [15:0] s_release_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_granted_offset,
    output logic        m_ok
);
    import ffha_pkg::*;

    cmd_t    cmd;
    status_t st;

    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    ffha_datapath #(
        .HEAP_BYTES (HEAP_BYTES),
        .UNIT_BYTES (UNIT_BYTES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .st               (st),
        .s_mode           (s_mode),
        .s_request_bytes  (s_request_bytes),
        .s_release_offset (s_release_offset),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_granted_offset (m_granted_offset),
        .m_ok             (m_ok)
    );

`include "first_fit_heap_allocator_assert.svh"

    `FFHA_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `FFHA_ASSERT_IMP(a_fail_zero_offset, aclk, aresetn, m_valid && !m_ok, m_granted_offset == 16'd0)

endmodule

FILE: rtl/ffha_div.sv
module ffha_div #(
    parameter int UNIT_BYTES = ffha_pkg::UNIT_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [ffha_pkg::DIV_W-1:0]          dividend,
    output logic                                busy,
    output logic [ffha_pkg::DIV_W-1:0]          quotient,
    output logic [$clog2(UNIT_BYTES)-1:0]       remainder
);
    import ffha_pkg::*;

    localparam int RW = $clog2(UNIT_BYTES);
    localparam int SH = DIV_W + RW;
    localparam int MW = DIV_W + 1;
    localparam int PW = DIV_W + MW;
    // rounded-up reciprocal of the unit size, exact for every DIV_W-bit dividend
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES));

    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic             busy_reg, busy_next;
    logic [PW-1:0]    prod;
    logic [DIV_W-1:0] quo_calc;

    assign prod     = PW'(dvd_reg) * PW'(RECIP);
    assign quo_calc = DIV_W'(prod >> SH);

    // dividend registered on start, quotient and remainder registered in the cycle after
    always_comb begin
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        busy_next = busy_reg;
        if (start) begin
            dvd_next  = dividend;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = quo_calc;
            rem_next  = RW'(dvd_reg - quo_calc * DIV_W'(UNIT_BYTES));
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/ffha_datapath.sv
module ffha_datapath #(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF,
    parameter int UNIT_BYTES = ffha_pkg::UNIT_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffha_pkg::cmd_t    cmd,
    output ffha_pkg::status_t st,
    input  logic              s_mode,
    input  logic [15:0]       s_request_bytes,
    input  logic [15:0]       s_release_offset,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_granted_offset,
    output logic              m_ok
);
    import ffha_pkg::*;

    localparam int END_U = (HEAP_BYTES - HDR_BYTES) / UNIT_BYTES;
    localparam int UW    = (END_U < 1) ? 1 : $clog2(END_U + 1);
    localparam int CW    = (UW > DIV_W) ? UW : DIV_W;
    localparam int EW    = 2 * UW + 2;
    localparam int DEPTH = END_U + 1;
    localparam int RW    = $clog2(UNIT_BYTES);

    // entry layout: own size, own in-use, prev size, prev in-use (sizes in units)
    logic [EW-1:0] mem [0:DEPTH-1];
    logic [EW-1:0] rd_reg;
    logic [EW-1:0] wdata;
    logic [UW-1:0] addr;
    logic          we, re;

    logic [UW-1:0]    b_reg, b_next;
    logic [UW-1:0]    sz_reg, sz_next;
    logic [DIV_W-1:0] need_reg, need_next;
    logic [UW:0]      np_reg, np_next;
    logic             np_keep_reg, np_keep_next;
    logic [UW:0]      bprev_reg, bprev_next;
    logic             mode_reg, ofs_low_reg;
    logic             m_valid_reg, m_valid_next;
    logic [15:0]      gofs_reg, gofs_next;
    logic             ok_reg, ok_next;

    logic             div_busy;
    logic [DIV_W-1:0] quotient, dividend;
    logic [RW-1:0]    remainder;

    logic [UW-1:0] rd_own_u, rd_prev_u;
    logic          rd_own_f, rd_prev_f;
    logic [UW-1:0] b_plus_sz, need_u, rem_u;
    logic [31:0]   ofs_full;

    assign rd_own_u  = rd_reg[EW-1 -: UW];
    assign rd_own_f  = rd_reg[UW+1];
    assign rd_prev_u = rd_reg[UW:1];
    assign rd_prev_f = rd_reg[0];
    assign b_plus_sz = b_reg + sz_reg;
    assign need_u    = UW'(need_reg);
    assign rem_u     = sz_reg - need_u;
    assign ofs_full  = 32'(b_reg) * 32'(UNIT_BYTES) + 32'(HDR_BYTES);

    assign dividend = s_mode ? DIV_W'(s_release_offset - 16'(HDR_BYTES))
                             : DIV_W'(s_request_bytes) + DIV_W'(HDR_BYTES + UNIT_BYTES - 1);

    ffha_div #(.UNIT_BYTES(UNIT_BYTES)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.op == OP_LOAD),
        .dividend  (dividend),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_comb begin
        st.div_done     = !div_busy;
        st.is_release   = mode_reg;
        st.rel_bad_addr = ofs_low_reg || (remainder != '0) || (CW'(quotient) >= CW'(END_U));
        st.at_end       = (CW'(b_reg) >= CW'(END_U));
        st.tag_zero     = (rd_own_u == '0);
        st.fit          = !rd_own_f && (CW'(rd_own_u) >= CW'(need_reg));
        st.exact        = (CW'(rd_own_u) == CW'(need_reg));
        st.rel_bad_tag  = (rd_own_u == '0) || !rd_own_f;
        st.prev_merge   = !bprev_reg[0] && (bprev_reg[UW:1] != '0) && (bprev_reg[UW:1] <= b_reg);
        st.next_free    = !rd_own_f && (rd_own_u != '0);
        st.out_free     = !m_valid_reg || m_ready;
    end

    always_comb begin
        we           = 1'b0;
        re           = 1'b0;
        addr         = b_reg;
        wdata        = '0;
        b_next       = b_reg;
        sz_next      = sz_reg;
        need_next    = need_reg;
        np_next      = np_reg;
        np_keep_next = np_keep_reg;
        bprev_next   = bprev_reg;
        m_valid_next = m_valid_reg && !m_ready;
        gofs_next    = gofs_reg;
        ok_next      = ok_reg;
        unique case (cmd.op)
            OP_INIT0: begin
                we    = 1'b1;
                addr  = '0;
                wdata = {UW'(END_U), 1'b0, UW'(0), 1'b1};
            end
            OP_INIT1: begin
                we    = 1'b1;
                addr  = UW'(END_U);
                wdata = {UW'(0), 1'b1, UW'(END_U), 1'b0};
            end
            OP_SETUP: begin
                need_next = quotient;
                b_next    = mode_reg ? UW'(quotient) : '0;
            end
            OP_B_RD: re = 1'b1;
            OP_A_CHK: begin
                if (st.fit) begin
                    we           = 1'b1;
                    wdata        = {(st.exact ? rd_own_u : need_u), 1'b1, rd_prev_u, rd_prev_f};
                    sz_next      = rd_own_u;
                    np_keep_next = st.exact;
                    np_next      = {UW'(rd_own_u - need_u), 1'b0};
                end else begin
                    b_next = b_reg + rd_own_u;
                end
            end
            OP_A_SPLIT: begin
                // remainder becomes a free block right after the granted one
                we    = 1'b1;
                addr  = b_reg + need_u;
                wdata = {rem_u, 1'b0, need_u, 1'b1};
            end
            OP_NXT_RD: begin
                re   = 1'b1;
                addr = b_plus_sz;
            end
            OP_NXT_WR_A: begin
                we    = 1'b1;
                addr  = b_plus_sz;
                wdata = {rd_own_u, rd_own_f, (np_keep_reg ? {rd_prev_u, 1'b1} : np_reg)};
            end
            OP_NXT_WR_R: begin
                we    = 1'b1;
                addr  = b_plus_sz;
                wdata = {rd_own_u, rd_own_f, sz_reg, 1'b0};
            end
            OP_R_CHK: begin
                if (!st.rel_bad_tag) begin
                    we         = 1'b1;
                    wdata      = {rd_own_u, 1'b0, rd_prev_u, rd_prev_f};
                    sz_next    = rd_own_u;
                    bprev_next = {rd_prev_u, rd_prev_f};
                end
            end
            OP_P_RD: begin
                re   = 1'b1;
                addr = b_reg - bprev_reg[UW:1];
            end
            OP_B_CLR: begin
                we     = 1'b1;
                wdata  = '0;
                b_next = b_reg - bprev_reg[UW:1];
            end
            OP_P_WR: begin
                we         = 1'b1;
                wdata      = {UW'(rd_own_u + sz_reg), 1'b0, rd_prev_u, rd_prev_f};
                sz_next    = rd_own_u + sz_reg;
                bprev_next = {rd_prev_u, rd_prev_f};
            end
            OP_X_CHK: begin
                if (st.next_free) begin
                    we      = 1'b1;
                    addr    = b_plus_sz;
                    wdata   = '0;
                    sz_next = sz_reg + rd_own_u;
                end
            end
            OP_X_WB: begin
                we    = 1'b1;
                wdata = {sz_reg, 1'b0, bprev_reg};
            end
            OP_OUT_A: begin
                m_valid_next = 1'b1;
                gofs_next    = ofs_full[15:0];
                ok_next      = 1'b1;
            end
            OP_OUT_R: begin
                m_valid_next = 1'b1;
                gofs_next    = '0;
                ok_next      = 1'b1;
            end
            OP_OUT_FAIL: begin
                m_valid_next = 1'b1;
                gofs_next    = '0;
                ok_next      = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rd_reg <= mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.op == OP_LOAD) begin
            mode_reg    <= s_mode;
            ofs_low_reg <= (s_release_offset < 16'(HDR_BYTES));
        end
        b_reg       <= b_next;
        sz_reg      <= sz_next;
        need_reg    <= need_next;
        np_reg      <= np_next;
        np_keep_reg <= np_keep_next;
        bprev_reg   <= bprev_next;
        gofs_reg    <= gofs_next;
        ok_reg      <= ok_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_granted_offset = gofs_reg;
    assign m_ok             = ok_reg;

endmodule

FILE: rtl/ffha_ctrl.sv
module ffha_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ffha_pkg::status_t st,
    output ffha_pkg::cmd_t    cmd
);
    import ffha_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT0:   state_next = S_INIT1;
            S_INIT1:   state_next = S_IDLE;
            S_IDLE:    if (s_valid) state_next = S_DIV;
            S_DIV:     if (st.div_done) state_next = S_SETUP;
            S_SETUP: begin
                priority if (!st.is_release) state_next = S_A_RD;
                else if (st.rel_bad_addr)    state_next = S_FAIL;
                else                         state_next = S_R_RD;
            end
            S_A_RD:    state_next = st.at_end ? S_FAIL : S_A_CHK;
            S_A_CHK: begin
                priority if (st.tag_zero) state_next = S_FAIL;
                else if (st.fit)          state_next = st.exact ? S_A_NRD : S_A_SPLIT;
                else                      state_next = S_A_RD;
            end
            S_A_SPLIT: state_next = S_A_NRD;
            S_A_NRD:   state_next = S_A_NWR;
            S_A_NWR:   state_next = S_DONE_A;
            S_R_RD:    state_next = S_R_CHK;
            S_R_CHK:   state_next = st.rel_bad_tag ? S_FAIL : S_R_NRD;
            S_R_NRD:   state_next = S_R_NWR;
            S_R_NWR:   state_next = st.prev_merge ? S_R_PRD : S_R_XRD;
            S_R_PRD:   state_next = S_R_BCLR;
            S_R_BCLR:  state_next = S_R_PWR;
            S_R_PWR:   state_next = S_R_XRD;
            S_R_XRD:   state_next = S_R_XCHK;
            // without a merge the read word is already the following header
            S_R_XCHK:  state_next = st.next_free ? S_R_XWB : S_R_FWR;
            S_R_XWB:   state_next = S_R_FRD;
            S_R_FRD:   state_next = S_R_FWR;
            S_R_FWR:   state_next = S_DONE_R;
            S_DONE_A, S_DONE_R, S_FAIL: if (st.out_free) state_next = S_IDLE;
            default:   state_next = S_INIT0;
        endcase
    end

    always_comb begin
        cmd.op  = OP_NONE;
        s_ready = 1'b0;
        unique case (state_reg)
            S_INIT0:   cmd.op = OP_INIT0;
            S_INIT1:   cmd.op = OP_INIT1;
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_LOAD;
            end
            S_SETUP:   cmd.op = OP_SETUP;
            S_A_RD:    cmd.op = st.at_end ? OP_NONE : OP_B_RD;
            S_A_CHK:   cmd.op = st.tag_zero ? OP_NONE : OP_A_CHK;
            S_A_SPLIT: cmd.op = OP_A_SPLIT;
            S_A_NRD, S_R_NRD, S_R_XRD, S_R_FRD: cmd.op = OP_NXT_RD;
            S_A_NWR:   cmd.op = OP_NXT_WR_A;
            S_R_NWR, S_R_FWR: cmd.op = OP_NXT_WR_R;
            S_R_RD:    cmd.op = OP_B_RD;
            S_R_CHK:   cmd.op = OP_R_CHK;
            S_R_PRD:   cmd.op = OP_P_RD;
            S_R_BCLR:  cmd.op = OP_B_CLR;
            S_R_PWR:   cmd.op = OP_P_WR;
            S_R_XCHK:  cmd.op = OP_X_CHK;
            S_R_XWB:   cmd.op = OP_X_WB;
            S_DONE_A:  if (st.out_free) cmd.op = OP_OUT_A;
            S_DONE_R:  if (st.out_free) cmd.op = OP_OUT_R;
            S_FAIL:    if (st.out_free) cmd.op = OP_OUT_FAIL;
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT0;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: dv/first_fit_heap_allocator_checker.sv
`default_nettype none

module first_fit_heap_allocator_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_mode,
    input  wire logic [15:0] s_request_bytes,
    input  wire logic [15:0] s_release_offset,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [15:0] m_granted_offset,
    input  wire logic        m_ok,
    output int               fail_count,
    output int               words_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int HEAP   = ffha_pkg::HEAP_BYTES_DEF;
    localparam int UNIT   = ffha_pkg::UNIT_BYTES_DEF;
    localparam int HDR    = ffha_pkg::HDR_BYTES;
    localparam int NUNITS = HEAP / UNIT + 1;
    localparam int ENDOFS = ((HEAP - HDR) / UNIT) * UNIT;

    typedef struct packed {
        logic [15:0] granted_offset;
        logic        ok;
    } grant_t;

    bit [16:0] own_size [NUNITS];
    bit [16:0] prev_tag [NUNITS];
    grant_t    grants_due [$];

    function automatic int unit_of(int ofs);
        int u;
        u = ofs / UNIT;
        if (u >= NUNITS) u = NUNITS - 1;
        return u;
    endfunction

    function automatic void format_heap();
        foreach (own_size[i]) begin
            own_size[i] = '0;
            prev_tag[i] = '0;
        end
        own_size[0] = 17'(ENDOFS);
        prev_tag[0] = 17'(1);
        own_size[unit_of(ENDOFS)] = 17'(1);
        prev_tag[unit_of(ENDOFS)] = 17'(ENDOFS);
    endfunction

    function automatic grant_t first_fit(int req);
        grant_t g;
        int need, b, sz, rem, nb;
        bit [16:0] t;
        g = '0;
        need = ((req + HDR + UNIT - 1) / UNIT) * UNIT;
        b = 0;
        while (b < ENDOFS) begin
            t = own_size[unit_of(b)];
            sz = int'({t[16:1], 1'b0});
            if (sz == 0) break;
            if (!t[0] && sz >= need) begin
                if (sz < need + HDR) begin
                    own_size[unit_of(b)] = 17'(sz | 1);
                    prev_tag[unit_of(b + sz)][0] = 1'b1;
                end else begin
                    rem = sz - need;
                    nb = b + need;
                    own_size[unit_of(b)] = 17'(need | 1);
                    own_size[unit_of(nb)] = 17'(rem);
                    prev_tag[unit_of(nb)] = 17'(need | 1);
                    prev_tag[unit_of(nb + rem)] = 17'(rem);
                end
                g.granted_offset = 16'((b + HDR) & 'hFFFF);
                g.ok = 1'b1;
                return g;
            end
            b += sz;
        end
        return g;
    endfunction

    function automatic grant_t give_back(int ofs);
        grant_t g;
        int b, sz, ps, p, n;
        bit [16:0] nt;
        g = '0;
        if (ofs < HDR) return g;
        b = ofs - HDR;
        if (b % UNIT != 0 || b >= ENDOFS) return g;
        if (own_size[unit_of(b)][16:1] == '0 || !own_size[unit_of(b)][0]) return g;
        sz = int'({own_size[unit_of(b)][16:1], 1'b0});
        own_size[unit_of(b)] = 17'(sz);
        prev_tag[unit_of(b + sz)] = 17'(sz);
        // merge into a free block below
        if (!prev_tag[unit_of(b)][0]) begin
            ps = int'({prev_tag[unit_of(b)][16:1], 1'b0});
            if (ps != 0 && ps <= b) begin
                p = b - ps;
                own_size[unit_of(p)] = 17'(int'({own_size[unit_of(p)][16:1], 1'b0}) + sz);
                own_size[unit_of(b)] = '0;
                prev_tag[unit_of(b)] = '0;
                b = p;
                sz = int'(own_size[unit_of(b)]);
            end
        end
        n = b + sz;
        nt = own_size[unit_of(n)];
        if (!nt[0] && nt[16:1] != '0) begin
            sz += int'({nt[16:1], 1'b0});
            own_size[unit_of(b)] = 17'(sz);
            own_size[unit_of(n)] = '0;
            prev_tag[unit_of(n)] = '0;
        end
        prev_tag[unit_of(b + sz)] = 17'(sz);
        g.ok = 1'b1;
        return g;
    endfunction

    assign words_pending = grants_due.size();

    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            format_heap();
            grants_due.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_mode == MODE_ALLOC) grants_due.push_back(first_fit(int'(s_request_bytes)));
                else grants_due.push_back(give_back(int'(s_release_offset)));
            end
            if (m_valid && m_ready) begin
                if (grants_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result word: offset %0d ok %0b",
                                 m_granted_offset, m_ok);
                    fail_count <= fail_count + 1;
                end else begin
                    want = grants_due.pop_front();
                    if (want.granted_offset !== m_granted_offset || want.ok !== m_ok) begin
                        if (fail_count < 10)
                            $display("result mismatch: offset exp %0d got %0d, ok exp %0b got %0b",
                                     want.granted_offset, m_granted_offset, want.ok, m_ok);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

`default_nettype wire

FILE: dv/first_fit_heap_allocator_tb.sv
`default_nettype none

module first_fit_heap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int MAX_CYCLES   = 20_000_000;
    localparam int RANDOM_WORDS = 1880;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic [15:0] s_request_bytes = '0;
    logic [15:0] s_release_offset = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_granted_offset;
    logic        m_ok;

    int fail_count;
    int words_pending;
    int cycles = 0;
    int stall_left = 0;
    bit gaps_on = 1'b1;

    logic [15:0] live_blocks [$];
    logic [15:0] past_blocks [$];

    first_fit_heap_allocator i_dut (.*);

    first_fit_heap_allocator_checker i_checker (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("[first_fit_heap_allocator] ERROR");
            $finish;
        end
    end

    // result side: stall count drawn per word, grants remembered for releases
    always @(posedge aclk) begin
        int s;
        s = stall_left;
        if (aresetn && m_valid && m_ready) begin
            s = gaps_on ? $urandom_range(0, 6) : 0;
            if (m_ok && m_granted_offset != 0) begin
                live_blocks.push_back(m_granted_offset);
                past_blocks.push_back(m_granted_offset);
            end
        end else if (s > 0) begin
            s = s - 1;
        end
        stall_left <= s;
        m_ready <= aresetn && (s == 0);
    end

    task automatic send_word(bit mode, logic [15:0] req, logic [15:0] ofs);
        int gap;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_request_bytes <= req;
        s_release_offset <= ofs;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_word();
        int pick, idx;
        logic [15:0] v;
        pick = $urandom_range(0, 99);
        if (live_blocks.size() > 150 && pick < 60) pick = 70;
        if (pick < 55) begin
            send_word(MODE_ALLOC, 16'($urandom_range(0, 600)), 16'($urandom));
        end else if (pick < 60) begin
            send_word(MODE_ALLOC, 16'($urandom), 16'($urandom));
        end else if (pick < 90 && live_blocks.size() > 0) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            v = live_blocks[idx];
            live_blocks.delete(idx);
            send_word(MODE_RELEASE, 16'($urandom), v);
        end else if (pick < 95 && past_blocks.size() > 0) begin
            // stale offset: double release or a header cleared by a merge
            v = past_blocks[$urandom_range(0, past_blocks.size() - 1)];
            send_word(MODE_RELEASE, 16'($urandom), v);
        end else begin
            v = 16'($urandom);
            if (v[2:0] == 3'b000) v[2:0] = 3'($urandom_range(1, 7));
            send_word(MODE_RELEASE, 16'($urandom), v);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // four 24-byte blocks, then release with merges on both sides
        send_word(MODE_ALLOC, 16'd16, 16'd0);
        send_word(MODE_ALLOC, 16'd16, 16'd0);
        send_word(MODE_ALLOC, 16'd16, 16'd0);
        send_word(MODE_ALLOC, 16'd16, 16'd0);
        send_word(MODE_RELEASE, 16'hFFFF, 16'd8);
        send_word(MODE_RELEASE, 16'd0, 16'd56);
        send_word(MODE_RELEASE, 16'd0, 16'd32);
        send_word(MODE_RELEASE, 16'd0, 16'd80);
        // whole heap in one exact fit, then nothing left
        send_word(MODE_ALLOC, 16'd65520, 16'd0);
        send_word(MODE_ALLOC, 16'd0, 16'd0);
        send_word(MODE_ALLOC, 16'hFFFF, 16'hFFFF);
        send_word(MODE_RELEASE, 16'd0, 16'd8);
        // bad releases: low, misaligned, double, cleared header
        send_word(MODE_RELEASE, 16'd0, 16'd0);
        send_word(MODE_RELEASE, 16'd0, 16'd4);
        send_word(MODE_RELEASE, 16'd0, 16'd12);
        send_word(MODE_RELEASE, 16'd0, 16'hFFFF);
        send_word(MODE_RELEASE, 16'd0, 16'd8);
        send_word(MODE_RELEASE, 16'd0, 16'd32);
        send_word(MODE_ALLOC, 16'd65521, 16'd0);
        send_word(MODE_ALLOC, 16'd1, 16'd0);
        send_word(MODE_ALLOC, 16'd0, 16'd0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 200 == 150) gaps_on = 1'b0;
            if (n % 200 == 0) gaps_on = 1'b1;
            send_random_word();
        end
        s_valid <= 1'b0;

        while (words_pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("[first_fit_heap_allocator] OK");
        end else begin
            $display("[first_fit_heap_allocator] ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
